// ===== hw/rtl/rne_pkg.sv =====
// Package for the Roman numeral encoder: state type, letter codes and digit helpers.
package rne_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIGIT,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SEL_ONE,
        SEL_FIVE,
        SEL_TEN
    } letter_sel_t;

    localparam int ValueWidth  = 12;
    localparam int SymbolWidth = 8;
    localparam int DigitWidth  = 4;
    localparam int PlaceWidth  = 2;
    localparam int PosWidth    = 3;
    localparam int WideWidth   = 14;

    localparam logic [PlaceWidth-1:0] PlaceOnes      = 2'd0;
    localparam logic [PlaceWidth-1:0] PlaceTens      = 2'd1;
    localparam logic [PlaceWidth-1:0] PlaceHundreds  = 2'd2;
    localparam logic [PlaceWidth-1:0] PlaceThousands = 2'd3;

    localparam logic [SymbolWidth-1:0] LetterI = 8'h49;
    localparam logic [SymbolWidth-1:0] LetterV = 8'h56;
    localparam logic [SymbolWidth-1:0] LetterX = 8'h58;
    localparam logic [SymbolWidth-1:0] LetterL = 8'h4C;
    localparam logic [SymbolWidth-1:0] LetterC = 8'h43;
    localparam logic [SymbolWidth-1:0] LetterD = 8'h44;
    localparam logic [SymbolWidth-1:0] LetterM = 8'h4D;

    localparam logic [DigitWidth-1:0] DigitFour = 4'd4;
    localparam logic [DigitWidth-1:0] DigitFive = 4'd5;
    localparam logic [DigitWidth-1:0] DigitNine = 4'd9;
    localparam int MaxDigit = 9;

    // Decimal weight of a place.
    function automatic logic [WideWidth-1:0] place_weight(input logic [PlaceWidth-1:0] place);
        logic [WideWidth-1:0] w;
        unique case (place)
            PlaceOnes:      w = 14'd1;
            PlaceTens:      w = 14'd10;
            PlaceHundreds:  w = 14'd100;
            PlaceThousands: w = 14'd1000;
            default:        w = 14'd1;
        endcase
        return w;
    endfunction

    // Decimal digit of the remainder at the given place. The remainder holds no
    // higher places, so the digit is the number of multiples of the weight below it.
    function automatic logic [DigitWidth-1:0] digit_of(
        input logic [ValueWidth-1:0] rem,
        input logic [PlaceWidth-1:0] place
    );
        logic [WideWidth-1:0]  w;
        logic [WideWidth-1:0]  ext;
        logic [DigitWidth-1:0] d;
        w   = place_weight(place);
        ext = {{(WideWidth-ValueWidth){1'b0}}, rem};
        d   = '0;
        for (int k = 1; k <= MaxDigit; k++) begin
            if (ext >= WideWidth'(k * w)) begin
                d = DigitWidth'(k);
            end
        end
        return d;
    endfunction

    // Amount that the digit takes off the remainder.
    function automatic logic [ValueWidth-1:0] digit_amount(
        input logic [DigitWidth-1:0] d,
        input logic [PlaceWidth-1:0] place
    );
        logic [WideWidth-1:0] prod;
        prod = WideWidth'({{(WideWidth-DigitWidth){1'b0}}, d} * place_weight(place));
        return prod[ValueWidth-1:0];
    endfunction

    function automatic logic [SymbolWidth-1:0] letter_for(
        input logic [PlaceWidth-1:0] place,
        input letter_sel_t           sel
    );
        logic [SymbolWidth-1:0] s;
        unique case (place)
            PlaceOnes:      s = (sel == SEL_ONE) ? LetterI : ((sel == SEL_FIVE) ? LetterV : LetterX);
            PlaceTens:      s = (sel == SEL_ONE) ? LetterX : ((sel == SEL_FIVE) ? LetterL : LetterC);
            PlaceHundreds:  s = (sel == SEL_ONE) ? LetterC : ((sel == SEL_FIVE) ? LetterD : LetterM);
            PlaceThousands: s = LetterM;
            default:        s = LetterM;
        endcase
        return s;
    endfunction

    // Number of letters that one digit produces at a place.
    function automatic logic [PosWidth-1:0] digit_len(
        input logic [DigitWidth-1:0] d,
        input logic [PlaceWidth-1:0] place
    );
        logic [PosWidth-1:0] n;
        if (place == PlaceThousands) begin
            n = d[PosWidth-1:0];
        end else if (d == DigitFour || d == DigitNine) begin
            n = 3'd2;
        end else if (d >= DigitFive) begin
            n = PosWidth'(d - DigitFour);
        end else begin
            n = d[PosWidth-1:0];
        end
        return n;
    endfunction

    // Letter at position pos within the letters of one digit.
    function automatic logic [SymbolWidth-1:0] letter_at(
        input logic [DigitWidth-1:0] d,
        input logic [PlaceWidth-1:0] place,
        input logic [PosWidth-1:0]   pos
    );
        letter_sel_t sel;
        if (place == PlaceThousands) begin
            sel = SEL_ONE;
        end else if (d == DigitFour) begin
            sel = (pos == '0) ? SEL_ONE : SEL_FIVE;
        end else if (d == DigitNine) begin
            sel = (pos == '0) ? SEL_ONE : SEL_TEN;
        end else if (d >= DigitFive) begin
            sel = (pos == '0) ? SEL_FIVE : SEL_ONE;
        end else begin
            sel = SEL_ONE;
        end
        return letter_for(place, sel);
    endfunction

endpackage

// ===== hw/rtl/roman_numeral_encoder.sv =====
// Top level of the Roman numeral encoder: digit sequencer and output register.
//
// Usage: a number of 0 to 4095 enters on the input channel (in_valid, in_ready,
// value). Its Roman numeral leaves on the output channel (out_valid, out_ready,
// symbol, last), one ASCII letter per beat, thousands first, with last set on
// the final letter. A zero input gives no beat at all.
// The sequencer works one decimal place per step: it first takes the digit
// off the remainder with a shared compare and subtract, then emits each
// letter of that digit in turn. Places whose digit is zero are passed over
// in the digit state, and the walk ends as soon as the remainder is zero.
// Before the first letter, one digit step is taken for each place from the
// thousands down to the first nonzero digit, and a letter is registered only
// when the output register is free. A number is accepted in idle and takes
// at most four digit steps plus one emit step per letter (3888 gives 15
// letters); in_ready is high only between numbers.
// A stall on the output holds the current letter in the output register and
// freezes the sequencer once it has a letter to emit; nothing is lost. The
// next number may be accepted while the final letter of the previous one
// still waits. Reset (rst_n low, asynchronous) returns the sequencer to idle
// and drops out_valid.
module roman_numeral_encoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [rne_pkg::ValueWidth-1:0]   value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rne_pkg::SymbolWidth-1:0]  symbol,
    output logic                             last
);

    rne_pkg::state_t                    state_reg, state_next;
    logic [rne_pkg::ValueWidth-1:0]     rem_reg, rem_next;
    logic [rne_pkg::PlaceWidth-1:0]     place_reg, place_next;
    logic [rne_pkg::DigitWidth-1:0]     digit_reg, digit_next;
    logic [rne_pkg::PosWidth-1:0]       pos_reg, pos_next;
    logic [rne_pkg::SymbolWidth-1:0]    symbol_reg, symbol_next;
    logic                               last_reg, last_next;
    logic                               valid_reg, valid_next;

    logic [rne_pkg::DigitWidth-1:0]     cur_digit;
    logic [rne_pkg::PosWidth-1:0]       cur_len;
    logic                               out_free;
    logic                               final_letter;

    assign cur_digit    = rne_pkg::digit_of(rem_reg, place_reg);
    assign cur_len      = rne_pkg::digit_len(digit_reg, place_reg);
    assign out_free     = !valid_reg || out_ready;
    assign final_letter = (pos_reg == cur_len - 3'd1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rne_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rne_pkg::S_DIGIT;
                end
            end
            rne_pkg::S_DIGIT:
            begin
                if (rem_reg == '0)
                begin
                    state_next = rne_pkg::S_IDLE;
                end
                else if (cur_digit != '0)
                begin
                    state_next = rne_pkg::S_EMIT;
                end
            end
            rne_pkg::S_EMIT:
            begin
                if (out_free && final_letter)
                begin
                    state_next = (rem_reg == '0) ? rne_pkg::S_IDLE : rne_pkg::S_DIGIT;
                end
            end
            default:
            begin
                state_next = rne_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        in_ready    = 1'b0;
        rem_next    = rem_reg;
        place_next  = place_reg;
        digit_next  = digit_reg;
        pos_next    = pos_reg;
        symbol_next = symbol_reg;
        last_next   = last_reg;
        valid_next  = out_ready ? 1'b0 : valid_reg;
        unique case (state_reg)
            rne_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                rem_next   = value;
                place_next = rne_pkg::PlaceThousands;
            end
            rne_pkg::S_DIGIT:
            begin
                // Take the digit off the remainder; a zero digit just moves on.
                rem_next   = rem_reg - rne_pkg::digit_amount(cur_digit, place_reg);
                digit_next = cur_digit;
                pos_next   = '0;
                if (cur_digit == '0)
                begin
                    place_next = place_reg - 2'd1;
                end
            end
            rne_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    symbol_next = rne_pkg::letter_at(digit_reg, place_reg, pos_reg);
                    // The remainder already lacks this digit, so zero means no
                    // letters follow.
                    last_next   = final_letter && (rem_reg == '0);
                    valid_next  = 1'b1;
                    pos_next    = pos_reg + 3'd1;
                    if (final_letter)
                    begin
                        place_next = place_reg - 2'd1;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rne_pkg::S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        place_reg  <= place_next;
        digit_reg  <= digit_next;
        pos_reg    <= pos_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
    end

    assign out_valid = valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;

endmodule

// ===== sim/tb.sv =====
// Testbench for the Roman numeral encoder: letter predictor, scoreboard and handshake drivers.
`timescale 1ns / 100ps

module tb;

    localparam int RandomNumbers = 350;
    localparam int HoldOffBeat   = 400;
    localparam int HoldOffCycles = 400;
    localparam int DrainCycles   = 40;

    typedef logic [rne_pkg::ValueWidth-1:0]  value_t;
    typedef logic [rne_pkg::SymbolWidth-1:0] symbol_t;

    typedef struct packed {
        symbol_t symbol;
        logic    last;
    } letter_beat_t;

    class numeral_scoreboard;
        letter_beat_t expected_letters[$];
        int errors = 0;
        int numbers_seen = 0;
        int zeros_seen = 0;
        int letters_checked = 0;
        int longest_run = 0;

        // One decimal digit below the thousands: subtractive pair for 4 and 9,
        // otherwise an optional five-letter followed by repeated unit letters.
        function void spell_digit(int digit, symbol_t one, symbol_t five, symbol_t ten);
            int units;
            units = digit;
            if (digit == 4) begin
                expected_letters.push_back('{one, 1'b0});
                expected_letters.push_back('{five, 1'b0});
            end else if (digit == 9) begin
                expected_letters.push_back('{one, 1'b0});
                expected_letters.push_back('{ten, 1'b0});
            end else begin
                if (digit >= 5) begin
                    expected_letters.push_back('{five, 1'b0});
                    units = digit - 5;
                end
                repeat (units) expected_letters.push_back('{one, 1'b0});
            end
        endfunction

        function void note_value(value_t number);
            int start_size;
            int thousands;
            int run_length;
            start_size = expected_letters.size();
            thousands  = number / 1000;
            numbers_seen++;
            repeat (thousands) expected_letters.push_back('{rne_pkg::LetterM, 1'b0});
            spell_digit((number / 100) % 10, rne_pkg::LetterC, rne_pkg::LetterD,
                        rne_pkg::LetterM);
            spell_digit((number / 10) % 10, rne_pkg::LetterX, rne_pkg::LetterL,
                        rne_pkg::LetterC);
            spell_digit(number % 10, rne_pkg::LetterI, rne_pkg::LetterV, rne_pkg::LetterX);
            run_length = expected_letters.size() - start_size;
            if (run_length == 0) begin
                zeros_seen++;
            end else begin
                expected_letters[expected_letters.size() - 1].last = 1'b1;
                if (run_length > longest_run) begin
                    longest_run = run_length;
                end
            end
        endfunction

        function void check_beat(symbol_t symbol, logic last);
            letter_beat_t want;
            if (expected_letters.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual symbol %h last %b",
                         $time, symbol, last);
                errors++;
                return;
            end
            want = expected_letters.pop_front();
            letters_checked++;
            if (symbol !== want.symbol) begin
                $display("%0t: symbol mismatch, expected %h (%s), actual %h",
                         $time, want.symbol, want.symbol, symbol);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_letters.size();
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    value_t  value = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    symbol_t symbol;
    logic    last;

    numeral_scoreboard sb = new;

    int tx_max_gap = 16;
    int rx_max_gap = 16;
    int rx_beats = 0;

    always #5 clk = ~clk;

    roman_numeral_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .last      (last)
    );

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready) begin
            sb.note_value(value);
        end
        if (rst_n && out_valid && out_ready) begin
            sb.check_beat(symbol, last);
        end
    end

    // Receiver: a random stall before each beat, plus one long hold-off that
    // lets the block fill up and back-pressure the sender.
    initial
    begin
        int stall;
        wait (rst_n);
        forever begin
            stall = $urandom_range(0, rx_max_gap);
            if (rx_beats == HoldOffBeat) begin
                stall = HoldOffCycles;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            rx_beats++;
        end
    end

    task automatic send_value(input value_t number);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= number;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // Mostly uniform numbers, with zeros and long runs built from the digits
    // that spell the most letters mixed in.
    function automatic value_t random_number();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            return '0;
        end else if (pick < 4) begin
            return value_t'($urandom_range(0, 4) * 1000 + ($urandom_range(0, 1) ? 888 : 999)
                            - (($urandom_range(0, 1) == 1) ? 0 : 111 * $urandom_range(0, 4)));
        end
        return value_t'($urandom_range(1, 4095));
    endfunction

    initial
    begin
        static value_t directed[] = '{0, 1, 3, 4, 5, 8, 9, 14, 40, 49, 90, 99, 400, 444, 900,
                                      999, 1000, 3888, 3999, 4000, 4094, 4095, 2730, 1365, 0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k]) begin
            send_value(directed[k]);
        end

        // Random part in four phases: both sides idling, neither idling,
        // only the receiver stalling, only the sender pausing.
        for (int phase = 0; phase < 4; phase++) begin
            tx_max_gap = (phase == 0 || phase == 3) ? 16 : 0;
            rx_max_gap = (phase == 0 || phase == 2) ? 16 : 0;
            repeat (RandomNumbers / 4) send_value(random_number());
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Converted %0d numbers (%0d zeros), checked %0d letters, longest run %0d.",
                 sb.numbers_seen, sb.zeros_seen, sb.letters_checked, sb.longest_run);
        $display("Both sides idled at random, ran back to back, and one long output hold-off.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout with %0d letters still expected", $time, sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
